// File: rtl/core/sfcr_pkg.sv
`timescale 1ns / 1ps
// Package for the serial frame and code receiver.
// Holds buffer sizing, byte codes, operation and state types, and the status record.
// No dependencies.
package sfcr_pkg;

	localparam int BUF_DEPTH   = 256;
	localparam int CODE_LIMIT  = 128;
	localparam int FRAME_LIMIT = 50;

	localparam int ADDR_W = $clog2(BUF_DEPTH);
	localparam int CNT_W  = $clog2(BUF_DEPTH + 1);

	localparam logic [7:0] BYTE_ACK      = 8'h06;
	localparam logic [7:0] BYTE_STX      = 8'h02;
	localparam logic [7:0] BYTE_ETX      = 8'h03;
	localparam logic [7:0] BYTE_CODE_END = 8'h3C;

	localparam logic [2:0] PADDR_PORT_SEL = 3'd0;

	typedef enum logic [1:0] {
		OP_RX   = 2'd0,
		OP_ARM  = 2'd1,
		OP_IDLE = 2'd2,
		OP_READ = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_WAIT_STX = 3'd1,
		ST_LEN_HI   = 3'd2,
		ST_LEN_LO   = 3'd3,
		ST_DATA     = 3'd4,
		ST_CHECK    = 3'd5,
		ST_CODE     = 3'd6
	} rx_state_t;

	typedef struct packed {
		logic             frame_ready;
		logic [CNT_W-1:0] byte_count;
		logic             enq_request;
		logic             code_mode;
		logic             port_select;
		logic [2:0]       receive_state;
	} status_t;

endpackage

// File: rtl/core/serial_frame_and_code_receiver.sv
`timescale 1ns / 1ps
// Top level of the serial frame and code receiver.
// Depends on sfcr_pkg; holds the capture buffer memory and the receive state machine.
//
// Takes one item per clock, back to back, unless result_ready stalls the outputs; each
// accepted item passes the synchronous capture buffer read, then the result register.
// Every stored byte is a single write into the capture buffer at the current count
// (at zero for a new frame or code), so a read issued in the next cycle already sees
// it. The BUF_DEPTH-byte capture buffer needs no clearing after reset; entries at or
// beyond the byte count read as zero. port_select_value sits at APB address 0.
module serial_frame_and_code_receiver
	import sfcr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,

	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,

	input  logic             item_valid,
	output logic             item_ready,
	input  logic [1:0]       operation,
	input  logic [7:0]       rx_byte,
	input  logic [7:0]       read_index,

	output logic             result_valid,
	input  logic             result_ready,
	output logic [7:0]       read_data,
	output logic             frame_ready,
	output logic [CNT_W-1:0] byte_count,
	output logic             enq_request,
	output logic             code_mode,
	output logic             port_select,
	output logic [2:0]       receive_state
);

	logic              port_sel_val_q;
	rx_state_t         state_q, nxt_state;
	logic [CNT_W-1:0]  cnt_q;
	logic              ready_q, code_q, port_q;

	logic [7:0]        cap_mem [BUF_DEPTH];
	logic [7:0]        rd_data_s1;

	logic              s1_valid;
	status_t           stat_s1;
	logic              rd_ok_s1;

	logic              out_valid_q;
	logic [7:0]        out_data_q;
	status_t           out_stat_q;

	logic              accept, do_rx, s1_adv, rd_en;
	op_t               op;
	logic              app_en, wr_fit;
	logic [CNT_W-1:0]  app_base, cnt_app;
	logic [7:0]        app_byte;
	logic              nxt_ready, nxt_code, nxt_port, enq;
	logic [ADDR_W-1:0] rd_addr;
	status_t           nxt_stat;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == PADDR_PORT_SEL[2]) ? {31'd0, port_sel_val_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_sel_val_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == PADDR_PORT_SEL[2]) begin
			port_sel_val_q <= pwdata[0];
		end
	end

	// Handshake
	assign s1_adv     = !out_valid_q || result_ready;
	assign item_ready = !s1_valid || s1_adv;
	assign accept     = item_valid && item_ready;
	assign op         = op_t'(operation);
	assign do_rx      = accept && op == OP_RX;
	assign rd_en      = accept && op == OP_READ;
	assign rd_addr    = ADDR_W'(read_index);

	// Byte append and flag update
	always_comb begin
		app_en    = 1'b0;
		app_base  = cnt_q;
		app_byte  = rx_byte;
		nxt_ready = ready_q;
		nxt_code  = code_q;
		nxt_port  = port_q;
		enq       = 1'b0;
		case (op)
			OP_RX: begin
				case (state_q)
					ST_IDLE: begin
						if (rx_byte == BYTE_ACK) begin
							enq = 1'b1;
						end else begin
							nxt_code = 1'b1;
							nxt_port = port_sel_val_q;
							app_base = '0;
							app_en   = 1'b1;
						end
					end
					ST_WAIT_STX: begin
						if (rx_byte == BYTE_STX) begin
							nxt_ready = 1'b0;
							app_base  = '0;
							app_en    = 1'b1;
						end
					end
					ST_LEN_HI, ST_LEN_LO, ST_DATA: begin
						app_en = 1'b1;
					end
					ST_CHECK: begin
						app_en    = 1'b1;
						nxt_ready = 1'b1;
					end
					ST_CODE: begin
						if (cnt_q < CNT_W'(CODE_LIMIT)) begin
							app_en = 1'b1;
							if (rx_byte == BYTE_CODE_END) begin
								nxt_ready = 1'b1;
								app_byte  = 8'd0;
							end
						end else begin
							app_base = '0;
						end
					end
					default: begin
						app_en = 1'b0;
					end
				endcase
			end
			OP_IDLE: begin
				nxt_ready = 1'b0;
			end
			default: begin
				app_en = 1'b0;
			end
		endcase
	end

	assign wr_fit  = app_en && app_base < CNT_W'(BUF_DEPTH);
	assign cnt_app = wr_fit ? app_base + CNT_W'(1) : app_base;

	// Next state
	always_comb begin
		nxt_state = state_q;
		case (op)
			OP_RX: begin
				case (state_q)
					ST_IDLE: begin
						if (rx_byte != BYTE_ACK) begin
							nxt_state = ST_CODE;
						end
					end
					ST_WAIT_STX: begin
						if (rx_byte == BYTE_STX) begin
							nxt_state = ST_LEN_HI;
						end
					end
					ST_LEN_HI: begin
						nxt_state = ST_LEN_LO;
					end
					ST_LEN_LO: begin
						nxt_state = ST_DATA;
					end
					ST_DATA: begin
						if (cnt_app > CNT_W'(FRAME_LIMIT)) begin
							nxt_state = ST_IDLE;
						end else if (rx_byte == BYTE_ETX) begin
							nxt_state = ST_CHECK;
						end
					end
					ST_CHECK: begin
						nxt_state = ST_CHECK;
					end
					ST_CODE: begin
						if (cnt_q >= CNT_W'(CODE_LIMIT)) begin
							nxt_state = ST_IDLE;
						end
					end
					default: begin
						nxt_state = ST_IDLE;
					end
				endcase
			end
			OP_ARM: begin
				nxt_state = ST_WAIT_STX;
			end
			OP_IDLE: begin
				nxt_state = ST_IDLE;
			end
			default: begin
				nxt_state = state_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ready_q <= 1'b0;
			code_q  <= 1'b0;
			port_q  <= 1'b0;
		end else if (accept) begin
			state_q <= nxt_state;
			cnt_q   <= cnt_app;
			ready_q <= nxt_ready;
			code_q  <= nxt_code;
			port_q  <= nxt_port;
		end
	end

	// Capture buffer
	always_ff @(posedge clk) begin
		if (do_rx && wr_fit) begin
			cap_mem[app_base[ADDR_W-1:0]] <= app_byte;
		end
		if (rd_en) begin
			rd_data_s1 <= cap_mem[rd_addr];
		end
	end

	always_comb begin
		nxt_stat.frame_ready   = nxt_ready;
		nxt_stat.byte_count    = cnt_app;
		nxt_stat.enq_request   = enq;
		nxt_stat.code_mode     = nxt_code;
		nxt_stat.port_select   = nxt_port;
		nxt_stat.receive_state = nxt_state;
	end

	// Stage 1: buffer read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (item_ready) begin
			s1_valid <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stat_s1  <= nxt_stat;
			rd_ok_s1 <= op == OP_READ && CNT_W'(read_index) < cnt_q;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid) begin
			out_stat_q <= stat_s1;
			out_data_q <= rd_ok_s1 ? rd_data_s1 : 8'd0;
		end
	end

	assign result_valid  = out_valid_q;
	assign read_data     = out_data_q;
	assign frame_ready   = out_stat_q.frame_ready;
	assign byte_count    = out_stat_q.byte_count;
	assign enq_request   = out_stat_q.enq_request;
	assign code_mode     = out_stat_q.code_mode;
	assign port_select   = out_stat_q.port_select;
	assign receive_state = out_stat_q.receive_state;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(BUF_DEPTH))
		else $error("byte count above buffer depth");

	a_wr_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(do_rx && wr_fit) |-> (item_valid && item_ready && op == OP_RX))
		else $error("buffer write without an accepted beat");

	a_code_flag: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CODE |-> code_q)
		else $error("code capture state without code flag");

	a_enq_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && enq_request) |-> receive_state == ST_IDLE)
		else $error("enquiry request outside idle");

	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && byte_count == '0) |-> read_data == 8'd0)
		else $error("nonzero read data from empty buffer");

endmodule
